>>> hw/rtl/tsm_pkg.sv
package tsm_pkg;

  // Q.14 unity and the constants of the checks, truncated to Q.14
  localparam logic [14:0] Q_ONE          = 15'd16384;
  localparam logic [13:0] K_FACTOR_BASE  = 14'd5734;   // 0.35
  localparam logic [14:0] K_FACTOR_SLOPE = 15'd10649;  // 0.65
  localparam logic [14:0] K_GAP_CRIT     = 15'd4096;   // 0.25
  localparam logic [14:0] K_GAP_HIGH     = 15'd1966;   // 0.12
  localparam logic [14:0] K_GAP_MED      = 15'd983;    // 0.06
  localparam logic [14:0] K_WL_VLIGHT    = 15'd3276;   // 0.20
  localparam logic [14:0] K_WL_LIGHT     = 15'd6553;   // 0.40
  localparam logic [14:0] K_VRAM_CRIT    = 15'd1310;   // 0.08
  localparam logic [14:0] K_VRAM_HIGH    = 15'd655;    // 0.04
  localparam logic [16:0] K_RES_LIMIT    = 17'd22118;  // 1.35
  localparam logic [16:0] K_DRIFT_LIMIT  = 17'd4915;   // 0.30
  localparam logic [14:0] K_ENT_LIMIT    = 15'd10649;  // 0.65
  localparam logic [13:0] K_ONE_BIT      = 14'd256;    // one whole bit in Q.8

  // Configuration reset values
  localparam logic [14:0] TARGET_GPU_RST = 15'd15565;
  localparam logic [14:0] VRAM_LIMIT_RST = 15'd15565;
  localparam logic [5:0]  BITS_LIMIT_RST = 6'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_TARGET_GPU = 2'd0;
  localparam logic [1:0] CFG_VRAM_LIMIT = 2'd1;
  localparam logic [1:0] CFG_BITS_LIMIT = 2'd2;

  typedef logic [2:0] sev_t;
  typedef logic [5:0] issue_t;

  localparam sev_t SEV_NONE = 3'd0;
  localparam sev_t SEV_LOW  = 3'd1;
  localparam sev_t SEV_MED  = 3'd2;
  localparam sev_t SEV_HIGH = 3'd3;
  localparam sev_t SEV_CRIT = 3'd4;

  // Issue bit positions
  localparam int ISS_CPU   = 0;
  localparam int ISS_GPU   = 1;
  localparam int ISS_VRAM  = 2;
  localparam int ISS_BITS  = 3;
  localparam int ISS_INTEG = 4;
  localparam int ISS_DRIFT = 5;

  // Operands of the per-item checks
  typedef struct packed {
    logic        on_gpu;
    logic        gpu_chk;
    logic [14:0] gap;
    logic [14:0] wl;
    logic [14:0] vram;
    logic [14:0] vlim;
    logic [12:0] ebits;
    logic [13:0] blim;
    logic        integ_ok;
    logic        drift_hit;
  } chk_in_t;

  typedef struct packed {
    issue_t issues;
    sev_t   sev;
  } chk_out_t;

  function automatic sev_t sev_max(input sev_t a, input sev_t b);
    return (b > a) ? b : a;
  endfunction

endpackage

>>> hw/rtl/tsm_if.sv
interface tsm_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [15:0] gpu_load;
  logic signed [15:0] vram_load;
  logic signed [15:0] workload;
  logic signed [15:0] entropy_collapse;
  logic signed [17:0] residual_level;
  logic signed [17:0] norm_drift;
  logic        [12:0] effective_bits;
  logic               integrity_ok;
  logic               on_gpu;

  modport source (
    output valid, kind, gpu_load, vram_load, workload, entropy_collapse,
           residual_level, norm_drift, effective_bits, integrity_ok, on_gpu,
    input  ready
  );
  modport sink (
    input  valid, kind, gpu_load, vram_load, workload, entropy_collapse,
           residual_level, norm_drift, effective_bits, integrity_ok, on_gpu,
    output ready
  );
endinterface

interface tsm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] update_count;
  logic [31:0] breach_count;
  logic [5:0]  sticky_issues;
  logic [2:0]  sticky_severity;
  logic [5:0]  step_issues;
  logic [2:0]  step_severity;

  modport source (
    output valid, update_count, breach_count, sticky_issues, sticky_severity,
           step_issues, step_severity,
    input  ready
  );
  modport sink (
    input  valid, update_count, breach_count, sticky_issues, sticky_severity,
           step_issues, step_severity,
    output ready
  );
endinterface

>>> hw/rtl/tsm_severity.sv
module tsm_severity (
  input  tsm_pkg::chk_in_t  chk_in,
  output tsm_pkg::chk_out_t chk_out
);

  tsm_pkg::sev_t   gpu_sev;
  tsm_pkg::sev_t   sev;
  tsm_pkg::issue_t issues;
  logic [14:0]     vram_over;
  logic [13:0]     bits_over;

  // Grade the GPU shortfall, then soften it under a light workload
  always_comb begin
    if (chk_in.gap >= tsm_pkg::K_GAP_CRIT) begin
      gpu_sev = tsm_pkg::SEV_CRIT;
    end else if (chk_in.gap >= tsm_pkg::K_GAP_HIGH) begin
      gpu_sev = tsm_pkg::SEV_HIGH;
    end else if (chk_in.gap >= tsm_pkg::K_GAP_MED) begin
      gpu_sev = tsm_pkg::SEV_MED;
    end else begin
      gpu_sev = tsm_pkg::SEV_LOW;
    end
    if (chk_in.wl < tsm_pkg::K_WL_VLIGHT) begin
      gpu_sev = (gpu_sev > 3'd2) ? gpu_sev - 3'd2 : tsm_pkg::SEV_NONE;
    end else if (chk_in.wl < tsm_pkg::K_WL_LIGHT) begin
      gpu_sev = (gpu_sev > 3'd1) ? gpu_sev - 3'd1 : tsm_pkg::SEV_NONE;
    end
  end

  assign vram_over = chk_in.vram - chk_in.vlim;
  assign bits_over = {1'b0, chk_in.ebits} - chk_in.blim;

  // Raise issue bits and merge severities
  always_comb begin
    issues = '0;
    sev    = tsm_pkg::SEV_NONE;
    if (!chk_in.on_gpu) begin
      issues[tsm_pkg::ISS_CPU] = 1'b1;
      sev = tsm_pkg::SEV_HIGH;
    end else if (chk_in.gpu_chk && (chk_in.gap != '0)) begin
      issues[tsm_pkg::ISS_GPU] = 1'b1;
      sev = gpu_sev;
    end
    if (chk_in.vram > chk_in.vlim) begin
      issues[tsm_pkg::ISS_VRAM] = 1'b1;
      if (vram_over >= tsm_pkg::K_VRAM_CRIT) begin
        sev = tsm_pkg::sev_max(sev, tsm_pkg::SEV_CRIT);
      end else if (vram_over >= tsm_pkg::K_VRAM_HIGH) begin
        sev = tsm_pkg::sev_max(sev, tsm_pkg::SEV_HIGH);
      end else begin
        sev = tsm_pkg::sev_max(sev, tsm_pkg::SEV_MED);
      end
    end
    if ({1'b0, chk_in.ebits} > chk_in.blim) begin
      issues[tsm_pkg::ISS_BITS] = 1'b1;
      sev = tsm_pkg::sev_max(sev, (bits_over >= tsm_pkg::K_ONE_BIT) ?
                                  tsm_pkg::SEV_CRIT : tsm_pkg::SEV_HIGH);
    end
    if (!chk_in.integ_ok) begin
      issues[tsm_pkg::ISS_INTEG] = 1'b1;
      sev = tsm_pkg::sev_max(sev, tsm_pkg::SEV_HIGH);
    end
    if (chk_in.drift_hit) begin
      issues[tsm_pkg::ISS_DRIFT] = 1'b1;
      sev = tsm_pkg::sev_max(sev, tsm_pkg::SEV_HIGH);
    end
  end

  assign chk_out.issues = issues;
  assign chk_out.sev    = sev;

endmodule

>>> hw/rtl/telemetry_severity_monitor.sv
// An update steps through S_IDLE (input transfer), S_FACTOR, S_GAP and S_FINISH,
// which loads the result register; a restart goes from S_IDLE to S_FINISH.
// S_FINISH waits while the result register stays full and unaccepted. No new
// item is taken until then. The single shared 15x15 multiplier is used twice per
// update (workload factor, then GPU gap). rst_n is synchronous, active low: it
// restores the configuration registers, clears counters and sticky state and
// empties the result register.
module telemetry_severity_monitor (
  input  logic            clk,
  input  logic            rst_n,
  tsm_in_if.sink          in_ch,
  tsm_out_if.source       out_ch,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [14:0]     cfg_wdata
);

  typedef enum logic [1:0] {S_IDLE, S_FACTOR, S_GAP, S_FINISH} state_t;

  state_t state_r;

  // Configuration
  logic [14:0] target_gpu_r;
  logic [14:0] vram_limit_r;
  logic [5:0]  bits_limit_r;

  // Captured item
  logic        kind_r;
  logic        on_gpu_r;
  logic        gpu_chk_r;
  logic [14:0] wl_r;
  logic [14:0] diff_r;
  logic [14:0] vram_r;
  logic [12:0] ebits_r;
  logic        integ_r;
  logic        drift_hit_r;

  // Shared multiplier
  logic [14:0] mul_a;
  logic [14:0] mul_b;
  logic [29:0] prod;
  logic [29:0] prod_r;
  logic [13:0] factor;

  // Monitor state
  logic [31:0]     updates_r;
  logic [31:0]     breaches_r;
  tsm_pkg::issue_t record_r;
  tsm_pkg::sev_t   worst_r;

  // Result register
  logic            out_valid_r;
  logic [31:0]     out_upd_r;
  logic [31:0]     out_brc_r;
  tsm_pkg::issue_t out_sticky_iss_r;
  tsm_pkg::sev_t   out_sticky_sev_r;
  tsm_pkg::issue_t out_step_iss_r;
  tsm_pkg::sev_t   out_step_sev_r;

  logic [14:0]       tgt_clamped;
  logic [14:0]       vlim_clamped;
  logic [14:0]       gpu_c;
  logic [14:0]       ent_c;
  logic              in_xfer;
  logic              out_free;
  tsm_pkg::chk_in_t  chk_in;
  tsm_pkg::chk_out_t chk_out;

  logic [31:0]     upd_nxt;
  logic [31:0]     brc_nxt;
  tsm_pkg::issue_t record_nxt;
  tsm_pkg::sev_t   worst_nxt;
  tsm_pkg::issue_t step_iss_nxt;
  tsm_pkg::sev_t   step_sev_nxt;

  function automatic logic [14:0] clamp_q14(input logic signed [15:0] v);
    if (v[15]) begin
      return '0;
    end else if (v[14:0] > tsm_pkg::Q_ONE || v[14:0] == '1) begin
      return tsm_pkg::Q_ONE;
    end else begin
      return v[14:0];
    end
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  assign tgt_clamped  = (target_gpu_r > tsm_pkg::Q_ONE) ? tsm_pkg::Q_ONE : target_gpu_r;
  assign vlim_clamped = (vram_limit_r > tsm_pkg::Q_ONE) ? tsm_pkg::Q_ONE : vram_limit_r;
  assign gpu_c        = clamp_q14(in_ch.gpu_load);
  assign ent_c        = clamp_q14(in_ch.entropy_collapse);

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // Select multiplier operands by step
  assign factor = tsm_pkg::K_FACTOR_BASE + prod_r[27:14];
  always_comb begin
    case (state_r)
      S_FACTOR: begin
        mul_a = wl_r;
        mul_b = tsm_pkg::K_FACTOR_SLOPE;
      end
      S_GAP: begin
        mul_a = diff_r;
        mul_b = {1'b0, factor};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  // Evaluate the checks on the captured item
  always_comb begin
    chk_in.on_gpu    = on_gpu_r;
    chk_in.gpu_chk   = gpu_chk_r;
    chk_in.gap       = prod_r[28:14];
    chk_in.wl        = wl_r;
    chk_in.vram      = vram_r;
    chk_in.vlim      = vlim_clamped;
    chk_in.ebits     = ebits_r;
    chk_in.blim      = {bits_limit_r, 8'd0};
    chk_in.integ_ok  = integ_r;
    chk_in.drift_hit = drift_hit_r;
  end

  tsm_severity u_severity (
    .chk_in  (chk_in),
    .chk_out (chk_out)
  );

  // Next monitor state for update or restart
  always_comb begin
    if (kind_r) begin
      upd_nxt      = '0;
      brc_nxt      = '0;
      record_nxt   = '0;
      record_nxt[tsm_pkg::ISS_CPU] = !on_gpu_r;
      worst_nxt    = on_gpu_r ? tsm_pkg::SEV_NONE : tsm_pkg::SEV_HIGH;
      step_iss_nxt = '0;
      step_sev_nxt = tsm_pkg::SEV_NONE;
    end else begin
      upd_nxt      = sat_inc(updates_r);
      brc_nxt      = (chk_out.issues != '0) ? sat_inc(breaches_r) : breaches_r;
      record_nxt   = record_r | chk_out.issues;
      worst_nxt    = tsm_pkg::sev_max(worst_r, chk_out.sev);
      step_iss_nxt = chk_out.issues;
      step_sev_nxt = chk_out.sev;
    end
  end

  // Sequencer, configuration, state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      target_gpu_r <= tsm_pkg::TARGET_GPU_RST;
      vram_limit_r <= tsm_pkg::VRAM_LIMIT_RST;
      bits_limit_r <= tsm_pkg::BITS_LIMIT_RST;
      updates_r    <= '0;
      breaches_r   <= '0;
      record_r     <= '0;
      worst_r      <= tsm_pkg::SEV_NONE;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tsm_pkg::CFG_TARGET_GPU: target_gpu_r <= cfg_wdata;
          tsm_pkg::CFG_VRAM_LIMIT: vram_limit_r <= cfg_wdata;
          tsm_pkg::CFG_BITS_LIMIT: bits_limit_r <= cfg_wdata[5:0];
          default: ;
        endcase
      end

      // Drop the result once taken, unless a new one is loaded below
      if (out_valid_r && out_ch.ready && state_r != S_FINISH) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            kind_r      <= in_ch.kind;
            on_gpu_r    <= in_ch.on_gpu;
            gpu_chk_r   <= tgt_clamped > gpu_c;
            diff_r      <= (tgt_clamped > gpu_c) ? tgt_clamped - gpu_c : '0;
            wl_r        <= clamp_q14(in_ch.workload);
            vram_r      <= clamp_q14(in_ch.vram_load);
            ebits_r     <= in_ch.effective_bits;
            integ_r     <= in_ch.integrity_ok;
            drift_hit_r <= (!in_ch.residual_level[17] &&
                            in_ch.residual_level[16:0] >= tsm_pkg::K_RES_LIMIT) ||
                           (!in_ch.norm_drift[17] &&
                            in_ch.norm_drift[16:0] >= tsm_pkg::K_DRIFT_LIMIT) ||
                           (ent_c >= tsm_pkg::K_ENT_LIMIT);
            state_r     <= in_ch.kind ? S_FINISH : S_FACTOR;
          end
        end
        S_FACTOR: begin
          prod_r  <= prod;
          state_r <= S_GAP;
        end
        S_GAP: begin
          prod_r  <= prod;
          state_r <= S_FINISH;
        end
        S_FINISH: begin
          if (out_free) begin
            updates_r        <= upd_nxt;
            breaches_r       <= brc_nxt;
            record_r         <= record_nxt;
            worst_r          <= worst_nxt;
            out_valid_r      <= 1'b1;
            out_upd_r        <= upd_nxt;
            out_brc_r        <= brc_nxt;
            out_sticky_iss_r <= record_nxt;
            out_sticky_sev_r <= worst_nxt;
            out_step_iss_r   <= step_iss_nxt;
            out_step_sev_r   <= step_sev_nxt;
            state_r          <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.update_count    = out_upd_r;
  assign out_ch.breach_count    = out_brc_r;
  assign out_ch.sticky_issues   = out_sticky_iss_r;
  assign out_ch.sticky_severity = out_sticky_sev_r;
  assign out_ch.step_issues     = out_step_iss_r;
  assign out_ch.step_severity   = out_step_sev_r;

  // Hold off new items for the whole sequence
  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ch.ready)
    else $error("input taken while an item is in progress");

  // Step issues are always part of the sticky record
  a_step_in_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_step_iss_r & ~out_sticky_iss_r) == '0))
    else $error("step issue missing from sticky record");

  // Worst severity covers the step severity and stays in range
  a_sev_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_sticky_sev_r >= out_step_sev_r &&
                     out_sticky_sev_r <= tsm_pkg::SEV_CRIT))
    else $error("severity out of order");

  // Breaches never outnumber updates
  a_breach_le_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_brc_r <= out_upd_r))
    else $error("breach count above update count");

endmodule

>>> sim/testbench.sv
module testbench;

  // Snapshot kinds and the register index that maps to nothing
  localparam logic       KIND_UPDATE  = 1'b0;
  localparam logic       KIND_RESTART = 1'b1;
  localparam logic [1:0] CFG_UNUSED   = 2'd3;

  // Q.14 thresholds of the checks, truncated
  localparam int UNIT_Q14    = 16384;
  localparam int WL_BASE     = 5734;
  localparam int WL_SLOPE    = 10649;
  localparam int GAP_CRIT    = 4096;
  localparam int GAP_HIGH    = 1966;
  localparam int GAP_MED     = 983;
  localparam int WL_VLIGHT   = 3276;
  localparam int WL_LIGHT    = 6553;
  localparam int VRAM_CRIT   = 1310;
  localparam int VRAM_HIGH   = 655;
  localparam int RES_LIMIT   = 22118;
  localparam int DRIFT_LIMIT = 4915;
  localparam int ENT_LIMIT   = 10649;
  localparam int BIT_Q8      = 256;

  localparam int PHASES          = 8;
  localparam int ITEMS_PER_PHASE = 130;
  localparam int SETTLE_CYCLES   = 8;
  localparam int STALL_AT        = 200;
  localparam int STALL_LEN       = 300;
  localparam int WATCHDOG_LIMIT  = 2000;

  typedef struct {
    logic               kind;
    logic signed [15:0] gpu_load;
    logic signed [15:0] vram_load;
    logic signed [15:0] workload;
    logic signed [15:0] entropy_collapse;
    logic signed [17:0] residual_level;
    logic signed [17:0] norm_drift;
    logic        [12:0] effective_bits;
    logic               integrity_ok;
    logic               on_gpu;
  } snapshot_t;

  typedef struct {
    logic [31:0]     update_count;
    logic [31:0]     breach_count;
    tsm_pkg::issue_t sticky_issues;
    tsm_pkg::sev_t   sticky_severity;
    tsm_pkg::issue_t step_issues;
    tsm_pkg::sev_t   step_severity;
  } report_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [14:0] cfg_wdata;

  tsm_in_if  in_bus ();
  tsm_out_if out_bus ();

  telemetry_severity_monitor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Register copies and monitor state as the block should hold them
  logic [14:0]     target_reg;
  logic [14:0]     vram_reg;
  logic [5:0]      bits_reg;
  logic [31:0]     updates_seen;
  logic [31:0]     breaches_seen;
  tsm_pkg::issue_t issue_record;
  tsm_pkg::sev_t   worst_sev;

  snapshot_t pending_snapshots[$];
  report_t   expected_reports[$];
  snapshot_t on_bus;
  report_t   got;
  report_t   want;

  int send_idle_pct = 30;
  int recv_idle_pct = 30;
  int hold_left = 0;
  int quiet_cycles = 0;
  int mismatch_count = 0;
  int snapshots_sent = 0;
  int restarts_sent = 0;
  int reports_seen = 0;
  int settings_used = 1;
  tsm_pkg::issue_t issues_covered = '0;
  logic [4:0]      sevs_covered = '0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [31:0] clamp_unit(input int v);
    if (v < 0) return 32'd0;
    if (v > UNIT_Q14) return UNIT_Q14;
    return v;
  endfunction

  function automatic logic [31:0] bump_count(input logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // Apply one snapshot to the monitor state and return the report it causes
  function automatic report_t score_snapshot(input snapshot_t s);
    report_t         r;
    logic [31:0]     gpu, vram, wl, ent, tgt, vlim, blim, factor, gap, over;
    int              res, drift;
    tsm_pkg::sev_t   sev, gsev;
    tsm_pkg::issue_t iss;
    iss = '0;
    sev = tsm_pkg::SEV_NONE;
    if (s.kind == KIND_RESTART) begin
      updates_seen  = '0;
      breaches_seen = '0;
      issue_record  = '0;
      worst_sev     = tsm_pkg::SEV_NONE;
      if (!s.on_gpu) begin
        issue_record[tsm_pkg::ISS_CPU] = 1'b1;
        worst_sev = tsm_pkg::SEV_HIGH;
      end
    end else begin
      gpu   = clamp_unit(s.gpu_load);
      vram  = clamp_unit(s.vram_load);
      wl    = clamp_unit(s.workload);
      ent   = clamp_unit(s.entropy_collapse);
      res   = s.residual_level;
      drift = s.norm_drift;
      tgt   = (target_reg > UNIT_Q14) ? UNIT_Q14 : target_reg;
      vlim  = (vram_reg > UNIT_Q14) ? UNIT_Q14 : vram_reg;
      blim  = bits_reg * BIT_Q8;
      updates_seen = bump_count(updates_seen);

      // GPU shortfall, or the CPU fallback that replaces it
      if (!s.on_gpu) begin
        iss[tsm_pkg::ISS_CPU] = 1'b1;
        sev = tsm_pkg::SEV_HIGH;
      end else if (tgt > gpu) begin
        factor = WL_BASE + ((WL_SLOPE * wl) >> 14);
        gap    = ((tgt - gpu) * factor) >> 14;
        if (gap > 0) begin
          iss[tsm_pkg::ISS_GPU] = 1'b1;
          if (gap >= GAP_CRIT) gsev = tsm_pkg::SEV_CRIT;
          else if (gap >= GAP_HIGH) gsev = tsm_pkg::SEV_HIGH;
          else if (gap >= GAP_MED) gsev = tsm_pkg::SEV_MED;
          else gsev = tsm_pkg::SEV_LOW;
          if (sev > gsev) gsev = sev;
          // light workload softens the shortfall
          if (wl < WL_VLIGHT)
            gsev = (gsev > tsm_pkg::SEV_MED) ? tsm_pkg::sev_t'(gsev - 3'd2)
                                             : tsm_pkg::SEV_NONE;
          else if (wl < WL_LIGHT)
            gsev = (gsev > tsm_pkg::SEV_LOW) ? tsm_pkg::sev_t'(gsev - 3'd1)
                                             : tsm_pkg::SEV_NONE;
          sev = gsev;
        end
      end

      if (vram > vlim) begin
        over = vram - vlim;
        iss[tsm_pkg::ISS_VRAM] = 1'b1;
        if (over >= VRAM_CRIT) gsev = tsm_pkg::SEV_CRIT;
        else if (over >= VRAM_HIGH) gsev = tsm_pkg::SEV_HIGH;
        else gsev = tsm_pkg::SEV_MED;
        if (gsev > sev) sev = gsev;
      end

      if (s.effective_bits > blim) begin
        iss[tsm_pkg::ISS_BITS] = 1'b1;
        gsev = ((s.effective_bits - blim) >= BIT_Q8) ? tsm_pkg::SEV_CRIT
                                                     : tsm_pkg::SEV_HIGH;
        if (gsev > sev) sev = gsev;
      end

      if (!s.integrity_ok) begin
        iss[tsm_pkg::ISS_INTEG] = 1'b1;
        if (tsm_pkg::SEV_HIGH > sev) sev = tsm_pkg::SEV_HIGH;
      end

      if (res >= RES_LIMIT || drift >= DRIFT_LIMIT || ent >= ENT_LIMIT) begin
        iss[tsm_pkg::ISS_DRIFT] = 1'b1;
        if (tsm_pkg::SEV_HIGH > sev) sev = tsm_pkg::SEV_HIGH;
      end

      if (iss != '0) begin
        breaches_seen = bump_count(breaches_seen);
        issue_record  = issue_record | iss;
      end
      if (sev > worst_sev) worst_sev = sev;
    end
    r.update_count    = updates_seen;
    r.breach_count    = breaches_seen;
    r.sticky_issues   = issue_record;
    r.sticky_severity = worst_sev;
    r.step_issues     = iss;
    r.step_severity   = sev;
    return r;
  endfunction

  // Nominal snapshot that trips no check under the reset registers
  function automatic snapshot_t quiet_snapshot();
    snapshot_t t;
    t.kind             = KIND_UPDATE;
    t.gpu_load         = 16'sd16000;
    t.vram_load        = 16'sd8000;
    t.workload         = 16'sd16384;
    t.entropy_collapse = 16'sd0;
    t.residual_level   = 18'sd0;
    t.norm_drift       = 18'sd0;
    t.effective_bits   = 13'd512;
    t.integrity_ok     = 1'b1;
    t.on_gpu           = 1'b1;
    return t;
  endfunction

  // Mostly snapshots aimed at the thresholds of the current registers, some noise
  function automatic snapshot_t random_snapshot();
    snapshot_t t;
    int tgt, vlim, blim, v;
    tgt  = (target_reg > UNIT_Q14) ? UNIT_Q14 : target_reg;
    vlim = (vram_reg > UNIT_Q14) ? UNIT_Q14 : vram_reg;
    blim = bits_reg * BIT_Q8;
    t.kind = ($urandom_range(0, 99) < 3) ? KIND_RESTART : KIND_UPDATE;
    if ($urandom_range(0, 9) == 0) begin
      t.gpu_load         = 16'($urandom());
      t.vram_load        = 16'($urandom());
      t.workload         = 16'($urandom());
      t.entropy_collapse = 16'($urandom());
      t.residual_level   = 18'($urandom());
      t.norm_drift       = 18'($urandom());
      t.effective_bits   = 13'($urandom());
      t.integrity_ok     = 1'($urandom());
      t.on_gpu           = 1'($urandom());
    end else begin
      v = ($urandom_range(0, 1) == 0) ? tgt - int'($urandom_range(0, 6000))
                                      : int'($urandom_range(0, UNIT_Q14));
      t.gpu_load = 16'(v);
      v = ($urandom_range(0, 1) == 0) ? vlim + int'($urandom_range(0, 2000)) - 300
                                      : int'($urandom_range(0, UNIT_Q14));
      t.vram_load = 16'(v);
      v = ($urandom_range(0, 9) == 0) ? -int'($urandom_range(1, 32768))
                                      : int'($urandom_range(0, UNIT_Q14));
      t.workload = 16'(v);
      t.entropy_collapse = 16'($urandom_range(0, 12000));
      v = ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 25000))
                                      : int'($urandom_range(0, 8000)) - 4000;
      t.residual_level = 18'(v);
      v = ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 5500))
                                      : int'($urandom_range(0, 2000)) - 1000;
      t.norm_drift = 18'(v);
      if ($urandom_range(0, 2) == 0) begin
        v = int'($urandom_range(0, 8191));
      end else begin
        v = blim + int'($urandom_range(0, 700)) - 400;
        if (v < 0) v = 0;
        if (v > 8191) v = 8191;
      end
      t.effective_bits = 13'(v);
      t.integrity_ok   = ($urandom_range(0, 99) >= 8);
      t.on_gpu         = ($urandom_range(0, 99) >= 7);
    end
    return t;
  endfunction

  task automatic write_register(input logic [1:0] idx, input logic [14:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      tsm_pkg::CFG_TARGET_GPU: target_reg = data;
      tsm_pkg::CFG_VRAM_LIMIT: vram_reg = data;
      tsm_pkg::CFG_BITS_LIMIT: bits_reg = data[5:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every snapshot is through and every report is in
  task automatic wait_settled();
    while (pending_snapshots.size() != 0 || in_bus.valid || expected_reports.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  // Sender: offer queued snapshots, predict each one on its transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        expected_reports.push_back(score_snapshot(on_bus));
        snapshots_sent++;
        if (on_bus.kind == KIND_RESTART) restarts_sent++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_snapshots.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          on_bus = pending_snapshots.pop_front();
          in_bus.valid            <= 1'b1;
          in_bus.kind             <= on_bus.kind;
          in_bus.gpu_load         <= on_bus.gpu_load;
          in_bus.vram_load        <= on_bus.vram_load;
          in_bus.workload         <= on_bus.workload;
          in_bus.entropy_collapse <= on_bus.entropy_collapse;
          in_bus.residual_level   <= on_bus.residual_level;
          in_bus.norm_drift       <= on_bus.norm_drift;
          in_bus.effective_bits   <= on_bus.effective_bits;
          in_bus.integrity_ok     <= on_bus.integrity_ok;
          in_bus.on_gpu           <= on_bus.on_gpu;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each report against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got.update_count    = out_bus.update_count;
        got.breach_count    = out_bus.breach_count;
        got.sticky_issues   = out_bus.sticky_issues;
        got.sticky_severity = out_bus.sticky_severity;
        got.step_issues     = out_bus.step_issues;
        got.step_severity   = out_bus.step_severity;
        if (expected_reports.size() == 0) begin
          $error("report arrived with no snapshot outstanding");
          mismatch_count++;
        end else begin
          want = expected_reports.pop_front();
          check_field("update_count", want.update_count, got.update_count);
          check_field("breach_count", want.breach_count, got.breach_count);
          check_field("sticky_issues", want.sticky_issues, got.sticky_issues);
          check_field("sticky_severity", want.sticky_severity, got.sticky_severity);
          check_field("step_issues", want.step_issues, got.step_issues);
          check_field("step_severity", want.step_severity, got.step_severity);
          issues_covered = issues_covered | want.step_issues;
          sevs_covered[want.step_severity] = 1'b1;
        end
        reports_seen++;
        // hold off once for a long stretch so the block backs up
        if (reports_seen == STALL_AT) hold_left = STALL_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)
        || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    snapshot_t t;
    rst_n                   = 1'b0;
    cfg_we                  = 1'b0;
    cfg_index               = tsm_pkg::CFG_TARGET_GPU;
    cfg_wdata               = '0;
    in_bus.valid            = 1'b0;
    in_bus.kind             = KIND_UPDATE;
    in_bus.gpu_load         = '0;
    in_bus.vram_load        = '0;
    in_bus.workload         = '0;
    in_bus.entropy_collapse = '0;
    in_bus.residual_level   = '0;
    in_bus.norm_drift       = '0;
    in_bus.effective_bits   = '0;
    in_bus.integrity_ok     = 1'b1;
    in_bus.on_gpu           = 1'b1;
    out_bus.ready           = 1'b0;
    target_reg    = tsm_pkg::TARGET_GPU_RST;
    vram_reg      = tsm_pkg::VRAM_LIMIT_RST;
    bits_reg      = tsm_pkg::BITS_LIMIT_RST;
    updates_seen  = '0;
    breaches_seen = '0;
    issue_record  = '0;
    worst_sev     = tsm_pkg::SEV_NONE;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed snapshots under the reset registers
    t = quiet_snapshot(); pending_snapshots.push_back(t);
    t.kind = KIND_RESTART; pending_snapshots.push_back(t);
    t = quiet_snapshot(); t.gpu_load = -16'sd32768; pending_snapshots.push_back(t);
    t = quiet_snapshot(); t.gpu_load = 16'sd32767; pending_snapshots.push_back(t);
    // very light and light workload soften a GPU shortfall
    t = quiet_snapshot(); t.gpu_load = 16'sd15000; t.workload = 16'sd0;
    pending_snapshots.push_back(t);
    t = quiet_snapshot(); t.gpu_load = 16'sd10000; t.workload = 16'sd5000;
    pending_snapshots.push_back(t);
    t = quiet_snapshot(); t.gpu_load = 16'sd0; t.workload = -16'sd32768;
    pending_snapshots.push_back(t);
    t = quiet_snapshot(); t.gpu_load = 16'sd12000; t.workload = 16'sd32767;
    pending_snapshots.push_back(t);
    // CPU fallback skips the GPU check
    t = quiet_snapshot(); t.on_gpu = 1'b0; t.gpu_load = 16'sd0; pending_snapshots.push_back(t);
    t = quiet_snapshot(); t.vram_load = 16'sd32767; pending_snapshots.push_back(t);
    t = quiet_snapshot(); t.vram_load = 16'sd16265; pending_snapshots.push_back(t);
    t = quiet_snapshot(); t.vram_load = 16'sd15665; pending_snapshots.push_back(t);
    t = quiet_snapshot(); t.vram_load = -16'sd32768; pending_snapshots.push_back(t);
    t = quiet_snapshot(); t.effective_bits = 13'd1023; pending_snapshots.push_back(t);
    t = quiet_snapshot(); t.effective_bits = 13'd8191; pending_snapshots.push_back(t);
    t = quiet_snapshot(); t.effective_bits = 13'd0; pending_snapshots.push_back(t);
    t = quiet_snapshot(); t.integrity_ok = 1'b0; pending_snapshots.push_back(t);
    t = quiet_snapshot(); t.residual_level = 18'sd131071; pending_snapshots.push_back(t);
    t = quiet_snapshot(); t.residual_level = -18'sd131072; t.norm_drift = 18'sd4915;
    pending_snapshots.push_back(t);
    t = quiet_snapshot(); t.norm_drift = -18'sd1; t.entropy_collapse = 16'sd10649;
    pending_snapshots.push_back(t);
    t = quiet_snapshot(); t.entropy_collapse = 16'sd32767; pending_snapshots.push_back(t);
    t = quiet_snapshot(); t.entropy_collapse = -16'sd32768; pending_snapshots.push_back(t);
    // restart into CPU fallback, then everything wrong at once
    t = quiet_snapshot(); t.kind = KIND_RESTART; t.on_gpu = 1'b0;
    pending_snapshots.push_back(t);
    t.kind = KIND_UPDATE; t.vram_load = 16'sd32767; t.effective_bits = 13'd8191;
    t.integrity_ok = 1'b0; t.norm_drift = 18'sd131071; pending_snapshots.push_back(t);
    wait_settled();

    // Random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin
          write_register(tsm_pkg::CFG_TARGET_GPU, 15'd16384);
          write_register(tsm_pkg::CFG_VRAM_LIMIT, 15'd16384);
          write_register(tsm_pkg::CFG_BITS_LIMIT, 15'd32);
        end
        1: begin
          write_register(tsm_pkg::CFG_TARGET_GPU, 15'd0);
          write_register(tsm_pkg::CFG_VRAM_LIMIT, 15'd0);
          write_register(tsm_pkg::CFG_BITS_LIMIT, 15'd0);
        end
        2: begin
          write_register(tsm_pkg::CFG_TARGET_GPU, 15'h7FFF);
          write_register(tsm_pkg::CFG_VRAM_LIMIT, 15'h7FFF);
          write_register(tsm_pkg::CFG_BITS_LIMIT, 15'h7FFF);
          write_register(CFG_UNUSED, 15'($urandom()));
        end
        default: begin
          write_register(tsm_pkg::CFG_TARGET_GPU, ($urandom_range(0, 4) == 0)
                         ? 15'($urandom()) : 15'($urandom_range(8000, 16384)));
          write_register(tsm_pkg::CFG_VRAM_LIMIT, ($urandom_range(0, 4) == 0)
                         ? 15'($urandom()) : 15'($urandom_range(8000, 16384)));
          write_register(tsm_pkg::CFG_BITS_LIMIT,
                         {9'($urandom()), 6'($urandom_range(0, 32))});
        end
      endcase
      settings_used++;
      // one phase runs with no idling on either side
      send_idle_pct = (p == 3) ? 0 : 30;
      recv_idle_pct = (p == 3) ? 0 : 30;
      for (int i = 0; i < ITEMS_PER_PHASE; i++)
        pending_snapshots.push_back(random_snapshot());
      wait_settled();
    end

    $display("Checked %0d reports for %0d snapshots (%0d restarts) under %0d register settings.",
             reports_seen, snapshots_sent, restarts_sent, settings_used);
    $display("Step issue bits raised %b, step severities seen %b.",
             issues_covered, sevs_covered);
    if (mismatch_count == 0 && expected_reports.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
